// ===== rtl/core/npgr_pkg.sv =====
// Package for the nearest pad grid resampler.
// Holds widths, opcodes, register indexes, reset values and the point entry type.
// No dependencies.
package npgr_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned CountW    = $clog2(MaxPoints + 1);
  localparam int unsigned CoordW    = 7;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned DistW     = CoordW + 1;
  localparam int unsigned AreaW     = 6;

  localparam logic [CoordW-1:0] GridSize   = 7'd105;
  localparam logic [AreaW-1:0]  CenterArea = 6'd25;
  localparam logic [AreaW-1:0]  OuterArea  = 6'd49;

  // ceil(2^shift / area): exact floor division of any 32-bit magnitude
  localparam logic [ValueW-1:0] RecipCenter      = 32'd1374389535;
  localparam int unsigned       RecipCenterShift = 35;
  localparam logic [ValueW-1:0] RecipOuter       = 32'd2804876602;
  localparam int unsigned       RecipOuterShift  = 37;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgAddrW-1:0] RegCenterLow   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegCenterHigh  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegInvalidCode = 3'd2;
  localparam logic [CfgAddrW-1:0] RegCenterReach = 3'd3;
  localparam logic [CfgAddrW-1:0] RegOuterReach  = 3'd4;

  localparam logic [CoordW-1:0] CenterLowRst   = 7'd35;
  localparam logic [CoordW-1:0] CenterHighRst  = 7'd70;
  localparam logic [ValueW-1:0] InvalidCodeRst = 32'h8000_0000;
  localparam logic [CoordW-1:0] CenterReachRst = 7'd2;
  localparam logic [CoordW-1:0] OuterReachRst  = 7'd3;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpLoad  = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ValueW-1:0] value;
  } point_t;

endpackage

// ===== rtl/core/nearest_pad_grid_resampler.sv =====
// Nearest pad grid resampler: point store, scan and reciprocal divide for grid cell queries.
// A query runs through the scan, multiply (StDiv) and output (StFin) states; a stalled
// earlier result holds the output state back. New transactions are stalled until the query
// is done; the scan reads one stored point a cycle from the point memory. Clear and load
// are taken in the idle state and do not stall the input.
// Reset clears the point count, the dropped flag and the control state and loads the
// configuration defaults; the point memory is not cleared.
module nearest_pad_grid_resampler (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [npgr_pkg::CfgAddrW-1:0]          cfg_addr_i,
  input  logic [npgr_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             opcode_i,
  input  logic [npgr_pkg::CoordW-1:0]            point_x_i,
  input  logic [npgr_pkg::CoordW-1:0]            point_y_i,
  input  logic signed [npgr_pkg::ValueW-1:0]     point_value_i,
  input  logic [npgr_pkg::CoordW-1:0]            cell_x_i,
  input  logic [npgr_pkg::CoordW-1:0]            cell_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [npgr_pkg::ValueW-1:0]     cell_value_o,
  output logic                                   cell_invalid_o,
  output logic [npgr_pkg::CoordW-1:0]            best_dist_x_o,
  output logic [npgr_pkg::CoordW-1:0]            best_dist_y_o,
  output logic                                   points_dropped_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  localparam int unsigned CW = npgr_pkg::CoordW;
  localparam int unsigned VW = npgr_pkg::ValueW;
  localparam int unsigned DW = npgr_pkg::DistW;

  function automatic logic in_center(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                     input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    in_center = (x >= lo) && (x < hi) && (y >= lo) && (y < hi);
  endfunction

  function automatic logic [DW-1:0] abs_diff(input logic signed [DW:0] a,
                                             input logic [CW-1:0] b);
    logic signed [DW:0] diff;
    diff = a - $signed({2'b00, b});
    abs_diff = diff[DW] ? DW'(-diff) : diff[DW-1:0];
  endfunction

  // configuration
  logic [CW-1:0] center_low_q, center_high_q, center_reach_q, outer_reach_q;
  logic [VW-1:0] invalid_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_low_q   <= npgr_pkg::CenterLowRst;
      center_high_q  <= npgr_pkg::CenterHighRst;
      invalid_code_q <= npgr_pkg::InvalidCodeRst;
      center_reach_q <= npgr_pkg::CenterReachRst;
      outer_reach_q  <= npgr_pkg::OuterReachRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        npgr_pkg::RegCenterLow:   center_low_q   <= cfg_data_i[CW-1:0];
        npgr_pkg::RegCenterHigh:  center_high_q  <= cfg_data_i[CW-1:0];
        npgr_pkg::RegInvalidCode: invalid_code_q <= cfg_data_i[VW-1:0];
        npgr_pkg::RegCenterReach: center_reach_q <= cfg_data_i[CW-1:0];
        npgr_pkg::RegOuterReach:  outer_reach_q  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [1:0]                     state_q, state_d;
  logic [npgr_pkg::CountW-1:0]    point_count_q, point_count_d;
  logic                           dropped_q, dropped_d;
  logic [npgr_pkg::CountW-1:0]    scan_idx_q, scan_idx_d;
  logic                           rd_vld_q, rd_vld_d;
  logic                           out_valid_q, out_valid_d;

  // query datapath
  logic                           central_q, central_d;
  logic signed [DW:0]             qx_q, qx_d, qy_q, qy_d;
  logic [CW-1:0]                  min_dx_q, min_dx_d, min_dy_q, min_dy_d;
  logic                           have_q, have_d;
  logic                           bad_q, bad_d;
  logic [VW-1:0]                  chosen_q, chosen_d;
  logic [VW-1:0]                  mag_q, mag_d;
  logic [2*VW-1:0]                prod_q, prod_d;
  logic                           neg_q, neg_d;

  // output register
  logic [VW-1:0]                  cell_value_q, cell_value_d;
  logic                           cell_invalid_q, cell_invalid_d;
  logic [CW-1:0]                  best_dx_q, best_dx_d, best_dy_q, best_dy_d;
  logic                           dropped_out_q, dropped_out_d;

  // point memory
  npgr_pkg::point_t               mem_q [npgr_pkg::MaxPoints];
  npgr_pkg::point_t               rd_data_q;
  logic                           mem_we, mem_re;
  npgr_pkg::point_t               mem_wdata;

  logic                           in_accept;
  logic [DW-1:0]                  dx, dy;
  logic                           match;
  logic [VW-1:0]                  recip;
  logic [VW-1:0]                  quot;
  logic [CW-1:0]                  reach;
  logic                           cell_central;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  assign mem_wdata.x     = point_x_i;
  assign mem_wdata.y     = point_y_i;
  assign mem_wdata.value = point_value_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[point_count_q[npgr_pkg::AddrW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[scan_idx_q[npgr_pkg::AddrW-1:0]];
    end
  end

  assign cell_central = in_center(cell_x_i, cell_y_i, center_low_q, center_high_q);
  assign dx      = abs_diff(qx_q, rd_data_q.x);
  assign dy      = abs_diff(qy_q, rd_data_q.y);
  assign match   = (in_center(rd_data_q.x, rd_data_q.y, center_low_q, center_high_q)
                    == central_q) && (dx <= {1'b0, min_dx_q}) && (dy <= {1'b0, min_dy_q});
  assign recip   = central_q ? npgr_pkg::RecipCenter : npgr_pkg::RecipOuter;
  assign quot    = central_q ? VW'(prod_q >> npgr_pkg::RecipCenterShift)
                             : VW'(prod_q >> npgr_pkg::RecipOuterShift);
  assign reach   = central_q ? center_reach_q : outer_reach_q;

  always_comb begin
    state_d        = state_q;
    point_count_d  = point_count_q;
    dropped_d      = dropped_q;
    scan_idx_d     = scan_idx_q;
    rd_vld_d       = 1'b0;
    out_valid_d    = out_valid_q && out_stall_i;
    central_d      = central_q;
    qx_d           = qx_q;
    qy_d           = qy_q;
    min_dx_d       = min_dx_q;
    min_dy_d       = min_dy_q;
    have_d         = have_q;
    bad_d          = bad_q;
    chosen_d       = chosen_q;
    mag_d          = mag_q;
    prod_d         = prod_q;
    neg_d          = neg_q;
    cell_value_d   = cell_value_q;
    cell_invalid_d = cell_invalid_q;
    best_dx_d      = best_dx_q;
    best_dy_d      = best_dy_q;
    dropped_out_d  = dropped_out_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          case (opcode_i)
            npgr_pkg::OpClear: begin
              point_count_d = '0;
              dropped_d     = 1'b0;
            end
            npgr_pkg::OpLoad: begin
              if (point_count_q < npgr_pkg::CountW'(npgr_pkg::MaxPoints)) begin
                mem_we        = 1'b1;
                point_count_d = point_count_q + 1'b1;
              end else begin
                dropped_d = 1'b1;
              end
            end
            npgr_pkg::OpQuery: begin
              central_d  = cell_central;
              qx_d       = cell_central ? (DW+1)'($signed({2'b00, cell_x_i}) + 1)
                                        : $signed({2'b00, cell_x_i});
              qy_d       = cell_central ? (DW+1)'($signed({2'b00, cell_y_i}) - 1)
                                        : $signed({2'b00, cell_y_i});
              min_dx_d   = npgr_pkg::GridSize;
              min_dy_d   = npgr_pkg::GridSize;
              have_d     = 1'b0;
              bad_d      = 1'b1;
              chosen_d   = '0;
              scan_idx_d = '0;
              state_d    = StScan;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (scan_idx_q < point_count_q) begin
          mem_re     = 1'b1;
          rd_vld_d   = 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
        end
        if (rd_vld_q && match) begin
          min_dx_d = dx[CW-1:0];
          min_dy_d = dy[CW-1:0];
          have_d   = 1'b1;
          bad_d    = (rd_data_q.value == invalid_code_q);
          chosen_d = rd_data_q.value;
        end
        if (scan_idx_q == point_count_q && !rd_vld_q) begin
          neg_d   = chosen_q[VW-1];
          mag_d   = chosen_q[VW-1] ? -chosen_q : chosen_q;
          state_d = StDiv;
        end
      end
      StDiv: begin
        prod_d  = (2*VW)'(mag_q) * (2*VW)'(recip);
        state_d = StFin;
      end
      StFin: begin
        if (!out_valid_q || !out_stall_i) begin
          cell_invalid_d = !have_q || bad_q || (min_dx_q > reach) || (min_dy_q > reach);
          cell_value_d   = cell_invalid_d ? invalid_code_q : (neg_q ? -quot : quot);
          best_dx_d      = min_dx_q;
          best_dy_d      = min_dy_q;
          dropped_out_d  = dropped_q;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      point_count_q <= '0;
      dropped_q     <= 1'b0;
      scan_idx_q    <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      point_count_q <= point_count_d;
      dropped_q     <= dropped_d;
      scan_idx_q    <= scan_idx_d;
      rd_vld_q      <= rd_vld_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    central_q      <= central_d;
    qx_q           <= qx_d;
    qy_q           <= qy_d;
    min_dx_q       <= min_dx_d;
    min_dy_q       <= min_dy_d;
    have_q         <= have_d;
    bad_q          <= bad_d;
    chosen_q       <= chosen_d;
    mag_q          <= mag_d;
    prod_q         <= prod_d;
    neg_q          <= neg_d;
    cell_value_q   <= cell_value_d;
    cell_invalid_q <= cell_invalid_d;
    best_dx_q      <= best_dx_d;
    best_dy_q      <= best_dy_d;
    dropped_out_q  <= dropped_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign cell_value_o     = cell_value_q;
  assign cell_invalid_o   = cell_invalid_q;
  assign best_dist_x_o    = best_dx_q;
  assign best_dist_y_o    = best_dy_q;
  assign points_dropped_o = dropped_out_q;

endmodule

// ===== bench/tb_nearest_pad_grid_resampler.sv =====
// Testbench for nearest_pad_grid_resampler: directed and random clear, load and query
// transactions, each result checked against an in-bench model of the point store and scan.
// Depends on npgr_pkg and the resampler RTL.
module tb_nearest_pad_grid_resampler;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int PhaseCount = 8;
  localparam int PhaseOps = 112;
  localparam int SettleCycles = npgr_pkg::MaxPoints + 48;
  localparam int QuietLimit = 6000;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    logic [1:0]                         opcode;
    logic [npgr_pkg::CoordW-1:0]        px;
    logic [npgr_pkg::CoordW-1:0]        py;
    logic signed [npgr_pkg::ValueW-1:0] pv;
    logic [npgr_pkg::CoordW-1:0]        cx;
    logic [npgr_pkg::CoordW-1:0]        cy;
  } grid_op_t;

  typedef struct {
    logic [npgr_pkg::CoordW-1:0]        cx;
    logic [npgr_pkg::CoordW-1:0]        cy;
    logic signed [npgr_pkg::ValueW-1:0] value;
    logic                               invalid;
    logic [npgr_pkg::CoordW-1:0]        dist_x;
    logic [npgr_pkg::CoordW-1:0]        dist_y;
    logic                               dropped;
  } cell_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [npgr_pkg::CfgAddrW-1:0]      cfg_addr = '0;
  logic [npgr_pkg::CfgDataW-1:0]      cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [1:0]                         opcode = npgr_pkg::OpClear;
  logic [npgr_pkg::CoordW-1:0]        point_x = '0;
  logic [npgr_pkg::CoordW-1:0]        point_y = '0;
  logic signed [npgr_pkg::ValueW-1:0] point_value = '0;
  logic [npgr_pkg::CoordW-1:0]        cell_x = '0;
  logic [npgr_pkg::CoordW-1:0]        cell_y = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [npgr_pkg::ValueW-1:0] cell_value;
  logic                               cell_invalid;
  logic [npgr_pkg::CoordW-1:0]        best_dist_x;
  logic [npgr_pkg::CoordW-1:0]        best_dist_y;
  logic                               points_dropped;

  grid_op_t     pending_ops[$];
  cell_result_t expected_cells[$];
  grid_op_t     cur_op;
  logic         op_taken = 1'b0;
  int           ops_queued = 0;
  int           ops_accepted = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  idle_mode_e   idle_mode = IdleNone;

  logic [npgr_pkg::CoordW-1:0]        pad_x[npgr_pkg::MaxPoints];
  logic [npgr_pkg::CoordW-1:0]        pad_y[npgr_pkg::MaxPoints];
  logic signed [npgr_pkg::ValueW-1:0] pad_val[npgr_pkg::MaxPoints];
  int                                 pad_count = 0;
  bit                                 pad_dropped = 1'b0;
  int                                 reg_center_low = int'(npgr_pkg::CenterLowRst);
  int                                 reg_center_high = int'(npgr_pkg::CenterHighRst);
  logic signed [npgr_pkg::ValueW-1:0] reg_invalid = npgr_pkg::InvalidCodeRst;
  int                                 reg_center_reach = int'(npgr_pkg::CenterReachRst);
  int                                 reg_outer_reach = int'(npgr_pkg::OuterReachRst);

  nearest_pad_grid_resampler uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .point_x_i        (point_x),
    .point_y_i        (point_y),
    .point_value_i    (point_value),
    .cell_x_i         (cell_x),
    .cell_y_i         (cell_y),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .cell_value_o     (cell_value),
    .cell_invalid_o   (cell_invalid),
    .best_dist_x_o    (best_dist_x),
    .best_dist_y_o    (best_dist_y),
    .points_dropped_o (points_dropped)
  );

  always #10 clk = ~clk;

  function automatic bit is_central(int x, int y);
    return x >= reg_center_low && x < reg_center_high &&
           y >= reg_center_low && y < reg_center_high;
  endfunction

  function automatic int clip7(int v);
    return v < 0 ? 0 : (v > 127 ? 127 : v);
  endfunction

  function automatic bit draw_idle(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic track_op(grid_op_t op);
    int           qx, qy, area, reach, mdx, mdy, dx, dy, v, chosen;
    bit           central, have, bad;
    cell_result_t res;
    case (op.opcode)
      npgr_pkg::OpClear: begin
        pad_count = 0;
        pad_dropped = 1'b0;
      end
      npgr_pkg::OpLoad: begin
        if (pad_count < npgr_pkg::MaxPoints) begin
          pad_x[pad_count] = op.px;
          pad_y[pad_count] = op.py;
          pad_val[pad_count] = op.pv;
          pad_count++;
        end else begin
          pad_dropped = 1'b1;
        end
      end
      npgr_pkg::OpQuery: begin
        central = is_central(int'(op.cx), int'(op.cy));
        qx = central ? int'(op.cx) + 1 : int'(op.cx);
        qy = central ? int'(op.cy) - 1 : int'(op.cy);
        area = central ? int'(npgr_pkg::CenterArea) : int'(npgr_pkg::OuterArea);
        reach = central ? reg_center_reach : reg_outer_reach;
        mdx = int'(npgr_pkg::GridSize);
        mdy = int'(npgr_pkg::GridSize);
        have = 1'b0;
        bad = 1'b1;
        chosen = 0;
        for (int k = 0; k < pad_count; k++) begin
          if (is_central(int'(pad_x[k]), int'(pad_y[k])) == central) begin
            dx = qx > int'(pad_x[k]) ? qx - int'(pad_x[k]) : int'(pad_x[k]) - qx;
            dy = qy > int'(pad_y[k]) ? qy - int'(pad_y[k]) : int'(pad_y[k]) - qy;
            if (dx <= mdx && dy <= mdy) begin
              mdx = dx;
              mdy = dy;
              have = 1'b1;
              bad = (pad_val[k] == reg_invalid);
              v = pad_val[k];
              chosen = v / area;
            end
          end
        end
        res.cx = op.cx;
        res.cy = op.cy;
        res.invalid = !have || bad || mdx > reach || mdy > reach;
        res.value = res.invalid ? reg_invalid : chosen;
        res.dist_x = mdx[npgr_pkg::CoordW-1:0];
        res.dist_y = mdy[npgr_pkg::CoordW-1:0];
        res.dropped = pad_dropped;
        expected_cells.insert(expected_cells.size(), res);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string what, cell_result_t e, longint want, longint got);
    if (want != got) begin
      $display("%0t: cell (%0d,%0d) %s: expected %0d actual %0d",
               $time, e.cx, e.cy, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : accept_ops
    if (rst_n && in_valid && !in_stall) begin
      track_op(cur_op);
      op_taken = 1'b1;
      ops_accepted++;
    end
  end

  always @(posedge clk) begin : monitor_cells
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected cell result: expected none actual value %0d",
                 $time, cell_value);
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        check_field("cell_value", want, want.value, cell_value);
        check_field("cell_invalid", want, want.invalid, cell_invalid);
        check_field("best_dist_x", want, want.dist_x, best_dist_x);
        check_field("best_dist_y", want, want.dist_y, best_dist_y);
        check_field("points_dropped", want, want.dropped, points_dropped);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_ops
    logic next_valid;
    if (!in_valid || op_taken) begin
      op_taken = 1'b0;
      next_valid = 1'b0;
      if (pending_ops.size() != 0 &&
          !draw_idle(idle_mode == IdleSender ? 52 : (idle_mode == IdleBoth ? 18 : 0))) begin
        cur_op = pending_ops.pop_front();
        next_valid = 1'b1;
        opcode <= cur_op.opcode;
        point_x <= cur_op.px;
        point_y <= cur_op.py;
        point_value <= cur_op.pv;
        cell_x <= cur_op.cx;
        cell_y <= cur_op.cy;
      end
      in_valid <= next_valid;
    end
  end

  always @(negedge clk) begin : drive_stall
    if (rst_n)
      out_stall <= draw_idle(idle_mode == IdleReceiver ? 52 : (idle_mode == IdleBoth ? 18 : 0));
  end

  function automatic grid_op_t make_op(logic [1:0] code);
    grid_op_t op;
    op.opcode = code;
    op.px = npgr_pkg::CoordW'($urandom);
    op.py = npgr_pkg::CoordW'($urandom);
    op.pv = $urandom;
    op.cx = npgr_pkg::CoordW'($urandom);
    op.cy = npgr_pkg::CoordW'($urandom);
    return op;
  endfunction

  function automatic grid_op_t load_op(int x, int y, logic signed [npgr_pkg::ValueW-1:0] v);
    grid_op_t op;
    op = make_op(npgr_pkg::OpLoad);
    op.px = x[npgr_pkg::CoordW-1:0];
    op.py = y[npgr_pkg::CoordW-1:0];
    op.pv = v;
    return op;
  endfunction

  function automatic grid_op_t query_op(int x, int y);
    grid_op_t op;
    op = make_op(npgr_pkg::OpQuery);
    op.cx = x[npgr_pkg::CoordW-1:0];
    op.cy = y[npgr_pkg::CoordW-1:0];
    return op;
  endfunction

  function automatic logic signed [npgr_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return reg_invalid;
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 8000000)) - 4000000;
    endcase
  endfunction

  task automatic queue_op(grid_op_t op);
    pending_ops.insert(pending_ops.size(), op);
    ops_queued++;
  endtask

  task automatic write_reg(logic [npgr_pkg::CfgAddrW-1:0] idx,
                           logic [npgr_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    case (idx)
      npgr_pkg::RegCenterLow:   reg_center_low = int'(data[npgr_pkg::CoordW-1:0]);
      npgr_pkg::RegCenterHigh:  reg_center_high = int'(data[npgr_pkg::CoordW-1:0]);
      npgr_pkg::RegInvalidCode: reg_invalid = data;
      npgr_pkg::RegCenterReach: reg_center_reach = int'(data[npgr_pkg::CoordW-1:0]);
      npgr_pkg::RegOuterReach:  reg_outer_reach = int'(data[npgr_pkg::CoordW-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_phase_regs(int ph);
    int lo, hi, cr, orr;
    logic [npgr_pkg::CfgDataW-1:0] code;
    case (ph)
      1: begin lo = 0; hi = 127; code = 32'h0; cr = 0; orr = 127; end
      2: begin lo = 80; hi = 20; code = 32'h7FFF_FFFF; cr = 127; orr = 0; end
      3: begin
        lo = $urandom_range(20, 50);
        hi = lo + $urandom_range(10, 50);
        code = $urandom;
        cr = $urandom_range(0, 4);
        orr = $urandom_range(1, 5);
      end
      4: begin
        lo = int'(npgr_pkg::CenterLowRst);
        hi = int'(npgr_pkg::CenterHighRst);
        code = npgr_pkg::InvalidCodeRst;
        cr = int'(npgr_pkg::CenterReachRst);
        orr = int'(npgr_pkg::OuterReachRst);
      end
      5: begin lo = 127; hi = 127; code = 32'hFFFF_FFFF; cr = 1; orr = 1; end
      6: begin
        lo = $urandom_range(0, 127);
        hi = $urandom_range(0, 127);
        code = $urandom;
        cr = $urandom_range(0, 127);
        orr = $urandom_range(0, 127);
      end
      default: begin lo = 10; hi = 100; code = 32'h8000_0000; cr = 3; orr = 2; end
    endcase
    write_reg(npgr_pkg::RegCenterLow, lo);
    write_reg(npgr_pkg::RegCenterHigh, hi);
    write_reg(npgr_pkg::RegInvalidCode, code);
    write_reg(npgr_pkg::RegCenterReach, cr);
    write_reg(npgr_pkg::RegOuterReach, orr);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_directed();
    queue_op(make_op(npgr_pkg::OpClear));
    queue_op(query_op(50, 50));
    queue_op(load_op(51, 49, 32'sh0019_0000));
    queue_op(load_op(51, 49, 32'sh7FFF_FFFF));
    queue_op(load_op(53, 47, -1));
    queue_op(query_op(50, 50));
    queue_op(load_op(0, 0, 32'sh8000_0001));
    queue_op(load_op(127, 127, 32'sh8000_0000));
    queue_op(query_op(0, 0));
    queue_op(query_op(127, 127));
    queue_op(query_op(3, 0));
    queue_op(query_op(4, 0));
    queue_op(make_op(OpUnused));
    queue_op(query_op(35, 35));
    queue_op(query_op(69, 69));
    queue_op(query_op(34, 34));
    queue_op(query_op(70, 70));
    queue_op(load_op(35, 35, 0));
    queue_op(query_op(34, 36));
    queue_op(query_op(35, 36));
    queue_op(query_op(0, 127));
    queue_op(query_op(104, 104));
  endtask

  task automatic queue_overflow();
    queue_op(make_op(npgr_pkg::OpClear));
    repeat (npgr_pkg::MaxPoints + $urandom_range(1, 3))
      queue_op(load_op(clip7(51 + int'($urandom_range(0, 8)) - 4),
                       clip7(49 + int'($urandom_range(0, 8)) - 4), pick_value()));
    queue_op(query_op(50, 50));
    queue_op(query_op(10, 10));
    queue_op(load_op(51, 49, 32'sh0001_0000));
    queue_op(query_op(50, 50));
  endtask

  task automatic queue_scenario();
    int pick, n, ax, ay, ox, oy;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) queue_op(make_op(2'($urandom_range(0, 3))));
    end else if (pick < 14) begin
      queue_op(query_op($urandom_range(0, 127), $urandom_range(0, 127)));
    end else begin
      if (reg_center_low < reg_center_high && $urandom_range(0, 1)) begin
        ax = $urandom_range(reg_center_low, reg_center_high - 1);
        ay = $urandom_range(reg_center_low, reg_center_high - 1);
      end else begin
        ax = $urandom_range(0, 127);
        ay = $urandom_range(0, 127);
      end
      ox = is_central(ax, ay) ? ax + 1 : ax;
      oy = is_central(ax, ay) ? ay - 1 : ay;
      if ($urandom_range(0, 9) != 0) queue_op(make_op(npgr_pkg::OpClear));
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0)
          queue_op(load_op($urandom_range(0, 127), $urandom_range(0, 127), pick_value()));
        else
          queue_op(load_op(clip7(ox + int'($urandom_range(0, 8)) - 4),
                           clip7(oy + int'($urandom_range(0, 8)) - 4), pick_value()));
      end
      n = $urandom_range(1, 4);
      repeat (n)
        queue_op(query_op(clip7(ax + int'($urandom_range(0, 2)) - 1),
                          clip7(ay + int'($urandom_range(0, 2)) - 1)));
    end
  endtask

  initial begin : run_phases
    int phase_start;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph > 0) set_phase_regs(ph);
      idle_mode = idle_mode_e'(ph % 4);
      phase_start = ops_queued;
      if (ph == 0) queue_directed();
      if (ph == 4) queue_overflow();
      while (ops_queued - phase_start < PhaseOps) queue_scenario();
      while (ops_accepted != ops_queued || expected_cells.size() != 0) @(negedge clk);
      repeat (SettleCycles) @(negedge clk);
    end
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
